[sv/block_map_heap_allocator_assert.svh]
// ----------------------------------------------------------------------------
// block_map_heap_allocator_assert.svh
// Assertion macros used by the allocator engine.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MAP_HEAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_MAP_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BMHA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BMHA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bmha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmha_pkg
// Types, codes and constants of the block map heap allocator.
// ----------------------------------------------------------------------------
package bmha_pkg;

	localparam int MAP_WORDS_DEF = 128;
	localparam int ENT_SHIFT     = 5;
	localparam int BLOCK_SHIFT   = 7;
	localparam int BYTES_W       = 20;
	localparam int NEED_W        = BYTES_W + 1 - BLOCK_SHIFT;
	localparam int ACTW_W        = 8;
	localparam logic [ACTW_W-1:0] ACTIVE_RESET = 8'd128;

	localparam logic [1:0] CODE_FREE = 2'b00;
	localparam logic [1:0] CODE_PART = 2'b11;
	localparam logic [1:0] CODE_END  = 2'b10;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [BYTES_W-1:0] request_bytes;
		logic [11:0]        block_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] result_block;
		logic        moved;
		logic [12:0] old_blocks;
		logic [12:0] used_blocks;
	} res_t;

endpackage

[sv/bmha_engine.sv]
`timescale 1ns / 1ps
`include "block_map_heap_allocator_assert.svh"
// ----------------------------------------------------------------------------
// bmha_engine
// Map memory and the sequencer that searches, walks, rewrites and recounts it.
// ----------------------------------------------------------------------------
module bmha_engine #(
	parameter int MAP_WORDS = bmha_pkg::MAP_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  bmha_pkg::cmd_t                 cmd,
	input  logic [$clog2(MAP_WORDS+1)-1:0] eff,
	output logic                           busy,
	output logic                           done,
	output bmha_pkg::res_t                 res
);
	import bmha_pkg::*;

	localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WCW = $clog2(MAP_WORDS + 1);
	localparam int BW  = WCW + ENT_SHIFT;
	localparam int XW  = ((BW > NEED_W) ? BW : NEED_W) + 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_SRGO  = 4'd3;
	localparam logic [3:0] S_SRCH  = 4'd4;
	localparam logic [3:0] S_WALK  = 4'd5;
	localparam logic [3:0] S_SWNX  = 4'd6;
	localparam logic [3:0] S_SWEEP = 4'd7;
	localparam logic [3:0] S_CNTGO = 4'd8;
	localparam logic [3:0] S_CNT   = 4'd9;

	logic [63:0] mem [MAP_WORDS];

	logic [3:0]     state_q;
	logic [1:0]     act_q;
	logic [XW-1:0]  n_q, bidx_q, len_q;
	logic [WCW-1:0] eff_q, rk_q, lim_q, zrun_q;
	logic           dv_s1;
	logic [WCW-1:0] dk_s1;
	logic [63:0]    rdata_s1;
	logic           first_q;
	logic [XW-1:0]  sa_q [3];
	logic [XW-1:0]  se_q [3];
	logic [1:0]     sc_q [3];
	logic [2:0]     sv_q;
	logic [1:0]     si_q;
	logic [BW-1:0]  cnt_q;
	logic [1:0]     status_q;
	logic [XW-1:0]  block_q, old_q;
	logic           moved_q;
	logic           done_q;
	res_t           res_q;

	logic           scan, issue, wr_en;
	logic [AW-1:0]  wr_addr;
	logic [63:0]    wr_data;
	logic [31:0]    free_v, part_v, endm_v;
	logic [XW-1:0]  tot_x, need_x;
	logic [BYTES_W:0] sum_b;
	logic           small_n;
	logic [31:0]    nmask, fit;
	logic           fit_any;
	logic [4:0]     fit_j;
	logic [XW-1:0]  q_x, zinc_x, w_x, s_x;
	logic [WCW-1:0] zinc;
	logic [4:0]     r5;
	logic [31:0]    rmask;
	logic           big_ok, srch_ok;
	logic [4:0]     p5, np_e;
	logic [31:0]    notpart;
	logic           np_any, first_ok;
	logic [5:0]     add6;
	logic [XW-1:0]  len_n;
	logic [XW-1:0]  cur_a, cur_e;
	logic [4:0]     lo5, hi5;
	logic [63:0]    new_word;
	logic [BW-1:0]  cnt_n;
	logic           last_word;

	// entry decode of the word just read
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			free_v[i] = (rdata_s1[2*i +: 2] == CODE_FREE);
			part_v[i] = (rdata_s1[2*i +: 2] == CODE_PART);
			endm_v[i] = (rdata_s1[2*i +: 2] == CODE_END);
		end
	end

	assign scan      = state_q inside {S_SRCH, S_WALK, S_SWEEP, S_CNT};
	assign issue     = scan && (rk_q <= lim_q);
	assign tot_x     = XW'({eff_q, 5'b0});
	assign sum_b     = (BYTES_W+1)'(cmd.request_bytes) + (BYTES_W+1)'((1 << BLOCK_SHIFT) - 1);
	assign need_x    = XW'(sum_b[BYTES_W:BLOCK_SHIFT]);
	assign last_word = (dk_s1 == lim_q);

	// first fit within one word
	always_comb begin
		small_n = (n_q <= XW'(32));
		nmask   = (n_q[5:0] == 6'd32) ? '1 : ((32'd1 << n_q[4:0]) - 32'd1);
		fit_any = 1'b0;
		fit_j   = '0;
		for (int j = 0; j < 32; j++)
			fit[j] = (((free_v >> j) & nmask) == nmask);
		for (int j = 31; j >= 0; j--) begin
			if (fit[j]) begin
				fit_any = 1'b1;
				fit_j   = 5'(j);
			end
		end
	end

	// whole free words followed by a free prefix
	always_comb begin
		q_x    = n_q >> ENT_SHIFT;
		r5     = n_q[4:0];
		zinc   = (rdata_s1 == '0) ? zrun_q + WCW'(1) : '0;
		zinc_x = XW'(zinc);
		rmask  = (32'd1 << r5) - 32'd1;
		if (r5 != '0)
			big_ok = (XW'(zrun_q) >= q_x) && ((free_v & rmask) == rmask);
		else
			big_ok = (zinc_x >= q_x);
		w_x = XW'(dk_s1) - q_x + ((r5 == '0) ? XW'(1) : XW'(0));
		if (small_n) begin
			srch_ok = fit_any;
			s_x     = XW'({dk_s1, fit_j});
		end else begin
			srch_ok = big_ok;
			s_x     = w_x << ENT_SHIFT;
		end
	end

	// run walk: stop at the first entry that does not continue the run
	always_comb begin
		p5       = first_q ? bidx_q[4:0] : 5'd0;
		first_ok = part_v[p5] | endm_v[p5];
		notpart  = ~part_v & ('1 << p5);
		np_any   = |notpart;
		np_e     = '0;
		for (int i = 31; i >= 0; i--)
			if (notpart[i]) np_e = 5'(i);
		if (np_any)
			add6 = {1'b0, np_e} - {1'b0, p5} + {5'd0, endm_v[np_e]};
		else
			add6 = 6'd32 - {1'b0, p5};
		len_n = len_q + XW'(add6);
	end

	// sweep rewrite of the entries of one word
	always_comb begin
		cur_a = sa_q[si_q];
		cur_e = se_q[si_q];
		lo5   = (dk_s1 == cur_a[WCW+4:5]) ? cur_a[4:0] : 5'd0;
		hi5   = (dk_s1 == cur_e[WCW+4:5]) ? cur_e[4:0] : 5'd31;
		for (int i = 0; i < 32; i++)
			new_word[2*i +: 2] = ((5'(i) >= lo5) && (5'(i) <= hi5)) ? sc_q[si_q]
				: rdata_s1[2*i +: 2];
	end

	assign cnt_n = cnt_q + BW'($countones(~free_v));

	assign wr_en   = (state_q == S_CLR) || ((state_q == S_SWEEP) && dv_s1);
	assign wr_addr = (state_q == S_CLR) ? rk_q[AW-1:0] : dk_s1[AW-1:0];
	assign wr_data = (state_q == S_CLR) ? 64'd0 : new_word;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (issue)
			rdata_s1 <= mem[rk_q[AW-1:0]];
		dk_s1 <= rk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rk_q    <= '0;
			lim_q   <= '0;
			dv_s1   <= 1'b0;
			done_q  <= 1'b0;
			sv_q    <= '0;
			si_q    <= '0;
		end else begin
			done_q <= 1'b0;
			dv_s1  <= issue;
			if (issue)
				rk_q <= rk_q + WCW'(1);
			case (state_q)
				S_CLR: begin
					if (rk_q == WCW'(MAP_WORDS - 1))
						state_q <= S_IDLE;
					else
						rk_q <= rk_q + WCW'(1);
				end
				S_IDLE: begin
					if (start) begin
						act_q    <= cmd.action;
						n_q      <= need_x;
						bidx_q   <= XW'(cmd.block_index);
						eff_q    <= eff;
						status_q <= ST_BAD;
						block_q  <= '0;
						moved_q  <= 1'b0;
						old_q    <= '0;
						sv_q     <= '0;
						si_q     <= '0;
						len_q    <= '0;
						first_q  <= 1'b1;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					case (act_q)
						ACT_ALLOC: begin
							state_q <= (n_q == '0) ? S_CNTGO : S_SRGO;
						end
						ACT_FREE: begin
							rk_q    <= bidx_q[WCW+4:5];
							lim_q   <= eff_q - WCW'(1);
							state_q <= (bidx_q >= tot_x) ? S_CNTGO : S_WALK;
						end
						ACT_RESIZE: begin
							rk_q    <= bidx_q[WCW+4:5];
							lim_q   <= eff_q - WCW'(1);
							state_q <= ((n_q == '0) || (bidx_q >= tot_x)) ? S_CNTGO : S_WALK;
						end
						default: state_q <= S_CNTGO;
					endcase
				end
				S_SRGO: begin
					rk_q    <= '0;
					lim_q   <= eff_q - WCW'(1);
					zrun_q  <= '0;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (dv_s1) begin
						zrun_q <= zinc;
						if (srch_ok) begin
							status_q <= ST_OK;
							block_q  <= s_x;
							sa_q[0]  <= s_x;
							se_q[0]  <= s_x + n_q - XW'(2);
							sc_q[0]  <= CODE_PART;
							sa_q[1]  <= s_x + n_q - XW'(1);
							se_q[1]  <= s_x + n_q - XW'(1);
							sc_q[1]  <= CODE_END;
							sa_q[2]  <= bidx_q;
							se_q[2]  <= bidx_q + len_q - XW'(1);
							sc_q[2]  <= CODE_FREE;
							sv_q     <= {act_q == ACT_RESIZE, 1'b1, n_q > XW'(1)};
							if (act_q == ACT_RESIZE) begin
								moved_q <= 1'b1;
								old_q   <= len_q;
							end
							state_q <= S_SWNX;
						end else if (last_word) begin
							status_q <= ST_NOFIT;
							state_q  <= S_CNTGO;
						end
					end
				end
				S_WALK: begin
					if (dv_s1) begin
						first_q <= 1'b0;
						len_q   <= len_n;
						if (first_q && !first_ok) begin
							state_q <= S_CNTGO;
						end else if (np_any || last_word) begin
							if (act_q == ACT_FREE) begin
								status_q <= ST_OK;
								sa_q[0]  <= bidx_q;
								se_q[0]  <= bidx_q + len_n - XW'(1);
								sc_q[0]  <= CODE_FREE;
								sv_q     <= 3'b001;
								state_q  <= S_SWNX;
							end else if (n_q <= len_n) begin
								// shrink in place: new end mark, drop the tail
								status_q <= ST_OK;
								block_q  <= bidx_q;
								old_q    <= len_n;
								sa_q[0]  <= bidx_q + n_q - XW'(1);
								se_q[0]  <= bidx_q + n_q - XW'(1);
								sc_q[0]  <= CODE_END;
								sa_q[1]  <= bidx_q + n_q;
								se_q[1]  <= bidx_q + len_n - XW'(1);
								sc_q[1]  <= CODE_FREE;
								sv_q     <= {1'b0, len_n > n_q, 1'b1};
								state_q  <= S_SWNX;
							end else begin
								state_q <= S_SRGO;
							end
						end
					end
				end
				S_SWNX: begin
					if (si_q == 2'd3) begin
						state_q <= S_CNTGO;
					end else if (sv_q[si_q]) begin
						rk_q    <= cur_a[WCW+4:5];
						lim_q   <= cur_e[WCW+4:5];
						state_q <= S_SWEEP;
					end else begin
						si_q <= si_q + 2'd1;
					end
				end
				S_SWEEP: begin
					if (dv_s1 && last_word) begin
						si_q    <= si_q + 2'd1;
						state_q <= S_SWNX;
					end
				end
				S_CNTGO: begin
					rk_q    <= '0;
					lim_q   <= eff_q - WCW'(1);
					cnt_q   <= '0;
					state_q <= S_CNT;
				end
				S_CNT: begin
					if (dv_s1) begin
						cnt_q <= cnt_n;
						if (last_word) begin
							res_q.status       <= status_q;
							res_q.result_block <= 12'(block_q);
							res_q.moved        <= moved_q;
							res_q.old_blocks   <= 13'(old_q);
							res_q.used_blocks  <= 13'(cnt_n);
							done_q             <= 1'b1;
							state_q            <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	`BMHA_ASSERT_IMP(a_moved_ok, clk, arst_n, done && res.moved, res.status == ST_OK, "moved flag on a failed word")
	`BMHA_ASSERT_IMP(a_fail_clean, clk, arst_n, done && (res.status != ST_OK), (res.result_block == '0) && (res.old_blocks == '0), "failed word carries a block or length")
	`BMHA_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted word did not raise busy")
	`BMHA_ASSERT_IMP(a_sweep_range, clk, arst_n, (state_q == S_SWEEP) && dv_s1, (dk_s1 <= lim_q) && (dk_s1 < eff_q), "map write outside active words")

endmodule

[sv/block_map_heap_allocator.sv]
`timescale 1ns / 1ps
// Every command walks, searches and sweeps map words as it needs, then recounts all A active
// map words; the recount over all active words is always paid.
// Throughput: one command at a time, set by the map memory, which is read one word per cycle;
// start is taken only while busy is low.
// Reset: after arst_n the map is zeroed with busy high; results cannot stall.
// ----------------------------------------------------------------------------
// block_map_heap_allocator
// Two-bit-per-block heap map allocator: allocate, free and resize with an APB register.
// ----------------------------------------------------------------------------
module block_map_heap_allocator #(
	parameter int MAP_WORDS = bmha_pkg::MAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [19:0] request_bytes,
	input  logic [11:0] block_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] result_block,
	output logic        moved,
	output logic [12:0] old_blocks,
	output logic [12:0] used_blocks
);
	import bmha_pkg::*;

	localparam int WCW = $clog2(MAP_WORDS + 1);

	logic [ACTW_W-1:0] active_words_q;
	logic [WCW-1:0]    eff;
	cmd_t              cmd;
	res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_words_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			active_words_q <= pwdata[ACTW_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(active_words_q);

	// clamp the word count to the range 1 to MAP_WORDS (zero reads as one word)
	always_comb begin
		if (active_words_q == '0)
			eff = WCW'(1);
		else if (int'(active_words_q) > MAP_WORDS)
			eff = WCW'(MAP_WORDS);
		else
			eff = WCW'(active_words_q);
	end

	assign cmd.action        = action;
	assign cmd.request_bytes = request_bytes;
	assign cmd.block_index   = block_index;

	bmha_engine #(
		.MAP_WORDS(MAP_WORDS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start && !busy),
		.cmd   (cmd),
		.eff   (eff),
		.busy  (busy),
		.done  (done),
		.res   (res)
	);

	assign status       = res.status;
	assign result_block = res.result_block;
	assign moved        = res.moved;
	assign old_blocks   = res.old_blocks;
	assign used_blocks  = res.used_blocks;

endmodule
